[sv/jsu_pkg.sv]
// types, codes and helper functions for the json string unescaper
package jsu_pkg;

    localparam int CP_W = 21;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_BODY,
        MODE_ESC,
        MODE_HEX_HI,
        MODE_WAIT_BS,
        MODE_WAIT_U,
        MODE_HEX_LO
    } mode_t;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_CLOSE = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_UNTERM  = 3'd1;
    localparam logic [2:0] ERR_ESCAPE  = 3'd2;
    localparam logic [2:0] ERR_HEX     = 3'd3;
    localparam logic [2:0] ERR_LOW_SUR = 3'd4;

    localparam logic [CP_W-1:0] CP_QUOTE     = 21'h22;
    localparam logic [CP_W-1:0] CP_SLASH     = 21'h2F;
    localparam logic [CP_W-1:0] CP_BACKSLASH = 21'h5C;
    localparam logic [CP_W-1:0] CP_B         = 21'h62;
    localparam logic [CP_W-1:0] CP_F         = 21'h66;
    localparam logic [CP_W-1:0] CP_N         = 21'h6E;
    localparam logic [CP_W-1:0] CP_R         = 21'h72;
    localparam logic [CP_W-1:0] CP_T         = 21'h74;
    localparam logic [CP_W-1:0] CP_U         = 21'h75;

    localparam logic [15:0] HIGH_SUR_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_SUR_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_SUR_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_SUR_LAST   = 16'hDFFF;
    localparam logic [CP_W-1:0] SUPP_BASE  = 21'h10000;
    localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;

    typedef struct packed {
        logic [2:0]      count;
        logic [3:0][7:0] bytes;   // bytes[0] goes out first
    } utf8_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    function automatic utf8_t utf8_encode(input logic [CP_W-1:0] c);
        utf8_t r;
        r.count = 3'd0;
        r.bytes = '0;
        if (c <= 21'h7F)
        begin
            r.count    = 3'd1;
            r.bytes[0] = c[7:0];
        end
        else if (c <= 21'h7FF)
        begin
            r.count    = 3'd2;
            r.bytes[0] = 8'hC0 | {3'b000, c[10:6]};
            r.bytes[1] = 8'h80 | {2'b00, c[5:0]};
        end
        else if (c <= 21'hFFFF)
        begin
            r.count    = 3'd3;
            r.bytes[0] = 8'hE0 | {4'b0000, c[15:12]};
            r.bytes[1] = 8'h80 | {2'b00, c[11:6]};
            r.bytes[2] = 8'h80 | {2'b00, c[5:0]};
        end
        else if (c <= CP_MAX)
        begin
            r.count    = 3'd4;
            r.bytes[0] = 8'hF0 | {5'b00000, c[20:18]};
            r.bytes[1] = 8'h80 | {2'b00, c[17:12]};
            r.bytes[2] = 8'h80 | {2'b00, c[11:6]};
            r.bytes[3] = 8'h80 | {2'b00, c[5:0]};
        end
        return r;
    endfunction

    function automatic hex_digit_t hex_decode(input logic [CP_W-1:0] c);
        hex_digit_t r;
        r.valid = 1'b1;
        r.value = 4'd0;
        if (c >= 21'h30 && c <= 21'h39)
        begin
            r.value = c[3:0];
        end
        else if ((c >= 21'h61 && c <= 21'h66) || (c >= 21'h41 && c <= 21'h46))
        begin
            r.value = c[3:0] + 4'd9;   // 'a' and 'A' both end in 0001
        end
        else
        begin
            r.valid = 1'b0;
        end
        return r;
    endfunction

endpackage

[sv/json_string_unescape_utf8.sv]
// json string body unescaper: code points in, utf-8 bytes and status out
//
// s_axis carries one code point per transaction. tuser[1] marks the opening
// quote (its code point becomes the closing delimiter), tuser[0] marks end of
// input. m_axis carries the results: a data byte, a string-closed marker or an
// error, with tlast on the final result of each input transaction.
// Each accepted transaction is decoded in the cycle it is taken and its zero
// to four results land in a four-entry result buffer; the first result is on
// m_axis the next cycle. Results drain one per cycle while m_axis_tready is high.
// Throughput: one input per cycle while every input gives at most one result and
// m_axis_tready stays high; an input that makes more than one utf-8 byte holds
// s_axis until the single-byte output port takes the last result from the buffer.
// s_axis_tready is high when the buffer is empty, or holds its last result
// and m_axis takes it in the same cycle. A stalled receiver therefore stalls
// the input after one pending result; nothing is dropped.
// Reset clears the buffer and puts the decoder in the idle mode, where every
// item except an opening quote is ignored.
module json_string_unescape_utf8 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [20:0] code_point, [23:21] zero
    input  logic [1:0]  s_axis_tuser,   // [0] end_of_input, [1] start_req
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [10:8] fault_code, [15:11] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast
);
    import jsu_pkg::*;

    mode_t           mode_reg, mode_next;
    logic [CP_W-1:0] quote_reg, quote_next;
    logic [15:0]     acc_reg, acc_next;
    logic [1:0]      digits_reg, digits_next;
    logic [9:0]      high_reg, high_next;

    logic [2:0]      cnt_reg;
    logic [3:0][7:0] byte_reg;
    kind_t           kind_reg;
    logic [2:0]      err_reg;

    logic [CP_W-1:0] in_cp;
    logic            in_eoi;
    logic            in_start;
    logic            in_fire;
    logic            out_fire;

    logic [2:0]      res_cnt;
    logic [3:0][7:0] res_bytes;
    logic [7:0]      res_byte;
    kind_t           res_kind;
    logic [2:0]      res_err;
    logic            enc_en;
    logic [CP_W-1:0] enc_cp;
    utf8_t           enc;
    hex_digit_t      hex;
    logic [15:0]     acc_shift;

    assign in_cp    = s_axis_tdata[CP_W-1:0];
    assign in_eoi   = s_axis_tuser[0];
    assign in_start = s_axis_tuser[1];

    assign s_axis_tready = (cnt_reg == 3'd0) || (cnt_reg == 3'd1 && m_axis_tready);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = m_axis_tvalid && m_axis_tready;

    assign hex       = hex_decode(in_cp);
    assign acc_shift = {acc_reg[11:0], hex.value};
    assign enc       = utf8_encode(enc_cp);

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            quote_reg  <= '0;
            acc_reg    <= '0;
            digits_reg <= '0;
            high_reg   <= '0;
        end
        else if (in_fire)
        begin
            mode_reg   <= mode_next;
            quote_reg  <= quote_next;
            acc_reg    <= acc_next;
            digits_reg <= digits_next;
            high_reg   <= high_next;
        end
    end

    always_comb
    begin
        mode_next   = mode_reg;
        quote_next  = quote_reg;
        acc_next    = acc_reg;
        digits_next = digits_reg;
        high_next   = high_reg;
        res_cnt     = 3'd0;
        res_byte    = 8'h00;
        res_kind    = KIND_DATA;
        res_err     = ERR_NONE;
        enc_en      = 1'b0;
        enc_cp      = in_cp;

        if (in_start)
        begin
            quote_next  = in_cp;
            mode_next   = MODE_BODY;
            acc_next    = '0;
            digits_next = '0;
            high_next   = '0;
        end
        else if (mode_reg != MODE_IDLE && in_eoi)
        begin
            mode_next = MODE_IDLE;
            res_cnt   = 3'd1;
            res_kind  = KIND_ERROR;
            unique case (mode_reg)
                MODE_BODY:                res_err = ERR_UNTERM;
                MODE_ESC:                 res_err = ERR_ESCAPE;
                MODE_HEX_HI, MODE_HEX_LO: res_err = ERR_HEX;
                default:                  res_err = ERR_LOW_SUR;
            endcase
        end
        else
        begin
            unique case (mode_reg)
                MODE_IDLE: ;
                MODE_BODY:
                begin
                    if (in_cp == quote_reg)
                    begin
                        res_cnt   = 3'd1;
                        res_kind  = KIND_CLOSE;
                        mode_next = MODE_IDLE;
                    end
                    else if (in_cp == CP_BACKSLASH)
                    begin
                        mode_next = MODE_ESC;
                    end
                    else
                    begin
                        enc_en = 1'b1;
                    end
                end
                MODE_ESC:
                begin
                    mode_next = MODE_BODY;
                    res_cnt   = 3'd1;
                    unique case (in_cp)
                        CP_QUOTE:     res_byte = 8'h22;
                        CP_BACKSLASH: res_byte = 8'h5C;
                        CP_SLASH:     res_byte = 8'h2F;
                        CP_B:         res_byte = 8'h08;
                        CP_F:         res_byte = 8'h0C;
                        CP_N:         res_byte = 8'h0A;
                        CP_R:         res_byte = 8'h0D;
                        CP_T:         res_byte = 8'h09;
                        CP_U:
                        begin
                            res_cnt     = 3'd0;
                            mode_next   = MODE_HEX_HI;
                            acc_next    = '0;
                            digits_next = '0;
                        end
                        default:
                        begin
                            mode_next = MODE_IDLE;
                            res_kind  = KIND_ERROR;
                            res_err   = ERR_ESCAPE;
                        end
                    endcase
                end
                MODE_HEX_HI, MODE_HEX_LO:
                begin
                    if (!hex.valid)
                    begin
                        mode_next = MODE_IDLE;
                        res_cnt   = 3'd1;
                        res_kind  = KIND_ERROR;
                        res_err   = ERR_HEX;
                    end
                    else
                    begin
                        acc_next = acc_shift;
                        if (digits_reg != 2'd3)
                        begin
                            digits_next = digits_reg + 2'd1;
                        end
                        else
                        begin
                            digits_next = '0;
                            if (mode_reg == MODE_HEX_HI)
                            begin
                                if (acc_shift >= HIGH_SUR_FIRST && acc_shift <= HIGH_SUR_LAST)
                                begin
                                    high_next = acc_shift[9:0];
                                    mode_next = MODE_WAIT_BS;
                                end
                                else
                                begin
                                    enc_en    = 1'b1;
                                    enc_cp    = {5'b00000, acc_shift};
                                    mode_next = MODE_BODY;
                                end
                            end
                            else if (acc_shift >= LOW_SUR_FIRST && acc_shift <= LOW_SUR_LAST)
                            begin
                                // join the pair into one supplementary code point
                                enc_en    = 1'b1;
                                enc_cp    = SUPP_BASE + {1'b0, high_reg, acc_shift[9:0]};
                                mode_next = MODE_BODY;
                            end
                            else
                            begin
                                mode_next = MODE_IDLE;
                                res_cnt   = 3'd1;
                                res_kind  = KIND_ERROR;
                                res_err   = ERR_LOW_SUR;
                            end
                        end
                    end
                end
                MODE_WAIT_BS:
                begin
                    if (in_cp == CP_BACKSLASH)
                    begin
                        mode_next = MODE_WAIT_U;
                    end
                    else
                    begin
                        mode_next = MODE_IDLE;
                        res_cnt   = 3'd1;
                        res_kind  = KIND_ERROR;
                        res_err   = ERR_LOW_SUR;
                    end
                end
                MODE_WAIT_U:
                begin
                    if (in_cp == CP_U)
                    begin
                        mode_next   = MODE_HEX_LO;
                        acc_next    = '0;
                        digits_next = '0;
                    end
                    else
                    begin
                        mode_next = MODE_IDLE;
                        res_cnt   = 3'd1;
                        res_kind  = KIND_ERROR;
                        res_err   = ERR_LOW_SUR;
                    end
                end
                default: mode_next = MODE_IDLE;
            endcase
        end

        if (enc_en)
        begin
            res_cnt   = enc.count;
            res_bytes = enc.bytes;
        end
        else
        begin
            res_bytes = {24'h000000, res_byte};
        end
    end

    // result buffer, drained from entry 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
        end
        else if (in_fire)
        begin
            cnt_reg <= res_cnt;
        end
        else if (out_fire)
        begin
            cnt_reg <= cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            byte_reg <= res_bytes;
            kind_reg <= res_kind;
            err_reg  <= res_err;
        end
        else if (out_fire)
        begin
            byte_reg <= {8'h00, byte_reg[3:1]};
        end
    end

    assign m_axis_tvalid = (cnt_reg != 3'd0);
    assign m_axis_tdata  = {5'b00000, err_reg, byte_reg[0]};
    assign m_axis_tuser  = kind_reg;
    assign m_axis_tlast  = (cnt_reg == 3'd1);

    // buffer never holds more than one utf-8 sequence
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 3'd4)
        else $error("result buffer count out of range");

    // markers and errors are always the only result of their transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != KIND_DATA)
            |-> (m_axis_tlast && m_axis_tdata[7:0] == 8'h00))
        else $error("non-data result not single or carries a byte");

    // an opening quote always opens the string body
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_start) |=> (mode_reg == MODE_BODY))
        else $error("start transaction did not open the string");

    // input is taken only when the buffer can hold the new results
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> (cnt_reg == 3'd0 || (cnt_reg == 3'd1 && out_fire)))
        else $error("input accepted over pending results");

endmodule

[dv/json_string_unescape_utf8_test.sv]
// self-checking testbench for the json string unescaper with utf-8 output
module json_string_unescape_utf8_test;
    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;

    localparam int TIMEOUT_CYCLES = 400000;
    localparam int TARGET_ITEMS   = 420;
    localparam int DRAIN_CYCLES   = 16;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            eoi;
        logic            start;
    } code_item_t;

    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
        logic [2:0] err;
        logic       last;
    } utf8_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // [20:0] code_point, [23:21] zero
    logic [1:0]  s_axis_tuser = '0;   // [0] end_of_input, [1] start_req
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // [7:0] out_byte, [10:8] fault_code, [15:11] zero
    logic [1:0]  m_axis_tuser;        // [1:0] kind
    logic        m_axis_tlast;

    json_string_unescape_utf8 uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    code_item_t   code_point_q[$];
    utf8_result_t expected_out_q[$];

    // decoder state mirrored by the predictor
    mode_t           dec_mode = MODE_IDLE;
    logic [CP_W-1:0] dec_quote = '0;
    logic [15:0]     dec_hex = '0;
    logic [1:0]      dec_digits = '0;
    logic [9:0]      dec_high = '0;

    utf8_result_t step_res[4];
    int           step_n;

    int  mismatch_count = 0;
    int  results_checked = 0;
    int  bytes_seen = 0;
    int  closes_seen = 0;
    int  errors_seen = 0;
    int  items_queued = 0;
    int  noise_queued = 0;
    int  strings_queued = 0;
    int  cycle_count = 0;
    bit  in_taken = 1'b0;
    int  burst_left = 1;
    int  gap_left = 0;
    int  stall_left = 0;
    logic [15:0] stall_pattern = 16'hFFFF;

    initial
    begin
        forever #10 clk = ~clk;
    end

    // ---------------- predictor ----------------

    task automatic emit(input logic [7:0] data, input kind_t kind, input logic [2:0] err);
        step_res[step_n] = '{data: data, kind: kind, err: err, last: 1'b0};
        step_n++;
    endtask

    task automatic flag_error(input logic [2:0] err);
        dec_mode = MODE_IDLE;
        emit(8'h00, KIND_ERROR, err);
    endtask

    task automatic emit_utf8(input logic [CP_W-1:0] c);
        if (c <= 21'h7F)
        begin
            emit(c[7:0], KIND_DATA, ERR_NONE);
        end
        else if (c <= 21'h7FF)
        begin
            emit({3'b110, c[10:6]}, KIND_DATA, ERR_NONE);
            emit({2'b10, c[5:0]}, KIND_DATA, ERR_NONE);
        end
        else if (c <= 21'hFFFF)
        begin
            emit({4'b1110, c[15:12]}, KIND_DATA, ERR_NONE);
            emit({2'b10, c[11:6]}, KIND_DATA, ERR_NONE);
            emit({2'b10, c[5:0]}, KIND_DATA, ERR_NONE);
        end
        else if (c <= CP_MAX)
        begin
            emit({5'b11110, c[20:18]}, KIND_DATA, ERR_NONE);
            emit({2'b10, c[17:12]}, KIND_DATA, ERR_NONE);
            emit({2'b10, c[11:6]}, KIND_DATA, ERR_NONE);
            emit({2'b10, c[5:0]}, KIND_DATA, ERR_NONE);
        end
        // anything beyond the unicode range is dropped silently
    endtask

    function automatic int nibble_of(input logic [CP_W-1:0] c);
        int v;
        v = -1;
        if (c >= 21'h30 && c <= 21'h39)
            v = int'(c - 21'h30);
        else if (c >= 21'h61 && c <= 21'h66)
            v = int'(c - 21'h61) + 10;
        else if (c >= 21'h41 && c <= 21'h46)
            v = int'(c - 21'h41) + 10;
        return v;
    endfunction

    task automatic unescape_item(input code_item_t it);
        int              v;
        logic [CP_W-1:0] joined;
        step_n = 0;
        if (it.start)
        begin
            dec_quote  = it.cp;
            dec_mode   = MODE_BODY;
            dec_hex    = '0;
            dec_digits = '0;
            dec_high   = '0;
        end
        else if (dec_mode != MODE_IDLE)
        begin
            if (it.eoi)
            begin
                case (dec_mode)
                    MODE_BODY:                flag_error(ERR_UNTERM);
                    MODE_ESC:                 flag_error(ERR_ESCAPE);
                    MODE_HEX_HI, MODE_HEX_LO: flag_error(ERR_HEX);
                    default:                  flag_error(ERR_LOW_SUR);
                endcase
            end
            else
            begin
                case (dec_mode)
                    MODE_BODY:
                    begin
                        // the closing quote wins over the backslash test
                        if (it.cp == dec_quote)
                        begin
                            emit(8'h00, KIND_CLOSE, ERR_NONE);
                            dec_mode = MODE_IDLE;
                        end
                        else if (it.cp == CP_BACKSLASH)
                        begin
                            dec_mode = MODE_ESC;
                        end
                        else
                        begin
                            emit_utf8(it.cp);
                        end
                    end
                    MODE_ESC:
                    begin
                        dec_mode = MODE_BODY;
                        case (it.cp)
                            CP_QUOTE:     emit(8'h22, KIND_DATA, ERR_NONE);
                            CP_BACKSLASH: emit(8'h5C, KIND_DATA, ERR_NONE);
                            CP_SLASH:     emit(8'h2F, KIND_DATA, ERR_NONE);
                            CP_B:         emit(8'h08, KIND_DATA, ERR_NONE);   // backspace
                            CP_F:         emit(8'h0C, KIND_DATA, ERR_NONE);   // form feed
                            CP_N:         emit(8'h0A, KIND_DATA, ERR_NONE);   // line feed
                            CP_R:         emit(8'h0D, KIND_DATA, ERR_NONE);   // carriage return
                            CP_T:         emit(8'h09, KIND_DATA, ERR_NONE);   // tab
                            CP_U:
                            begin
                                dec_mode   = MODE_HEX_HI;
                                dec_hex    = '0;
                                dec_digits = '0;
                            end
                            default:      flag_error(ERR_ESCAPE);
                        endcase
                    end
                    MODE_HEX_HI, MODE_HEX_LO:
                    begin
                        v = nibble_of(it.cp);
                        if (v < 0)
                        begin
                            flag_error(ERR_HEX);
                        end
                        else
                        begin
                            dec_hex = {dec_hex[11:0], v[3:0]};
                            if (dec_digits != 2'd3)
                            begin
                                dec_digits++;
                            end
                            else
                            begin
                                dec_digits = '0;
                                if (dec_mode == MODE_HEX_HI)
                                begin
                                    if (dec_hex >= HIGH_SUR_FIRST
                                        && dec_hex <= HIGH_SUR_LAST)
                                    begin
                                        dec_high = dec_hex[9:0];
                                        dec_mode = MODE_WAIT_BS;
                                    end
                                    else
                                    begin
                                        emit_utf8({5'd0, dec_hex});
                                        dec_mode = MODE_BODY;
                                    end
                                end
                                else if (dec_hex >= LOW_SUR_FIRST
                                         && dec_hex <= LOW_SUR_LAST)
                                begin
                                    joined = SUPP_BASE + {1'b0, dec_high, dec_hex[9:0]};
                                    emit_utf8(joined);
                                    dec_mode = MODE_BODY;
                                end
                                else
                                begin
                                    flag_error(ERR_LOW_SUR);
                                end
                            end
                        end
                    end
                    MODE_WAIT_BS:
                    begin
                        if (it.cp == CP_BACKSLASH)
                            dec_mode = MODE_WAIT_U;
                        else
                            flag_error(ERR_LOW_SUR);
                    end
                    MODE_WAIT_U:
                    begin
                        if (it.cp == CP_U)
                        begin
                            dec_mode   = MODE_HEX_LO;
                            dec_hex    = '0;
                            dec_digits = '0;
                        end
                        else
                        begin
                            flag_error(ERR_LOW_SUR);
                        end
                    end
                    default:
                        dec_mode = MODE_IDLE;
                endcase
            end
        end
        for (int i = 0; i < step_n; i++)
        begin
            step_res[i].last = (i == step_n - 1);
            expected_out_q.push_back(step_res[i]);
        end
    endtask

    // ---------------- stimulus builders ----------------

    task automatic add_item(input logic [CP_W-1:0] cp, input logic eoi, input logic start);
        code_point_q.push_back('{cp: cp, eoi: eoi, start: start});
        items_queued++;
    endtask

    task automatic push_cp(input logic [CP_W-1:0] cp);
        add_item(cp, 1'b0, 1'b0);
    endtask

    task automatic push_eoi();
        add_item(CP_W'($urandom_range(0, 21'h1FFFFF)), 1'b1, 1'b0);
    endtask

    task automatic push_start(input logic [CP_W-1:0] quote);
        add_item(quote, 1'b0, 1'b1);
        strings_queued++;
    endtask

    function automatic logic [CP_W-1:0] hex_char(input int v);
        logic [CP_W-1:0] c;
        if (v < 10)
            c = CP_W'(v) + 21'h30;
        else if ($urandom_range(0, 1) == 1)
            c = CP_W'(v - 10) + 21'h61;
        else
            c = CP_W'(v - 10) + 21'h41;
        return c;
    endfunction

    task automatic push_hex_digits(input logic [15:0] value, input int count);
        for (int i = 0; i < count; i++)
            push_cp(hex_char(int'(value[15 - 4*i -: 4])));
    endtask

    task automatic push_unicode_escape(input logic [15:0] value);
        push_cp(CP_BACKSLASH);
        push_cp(CP_U);
        push_hex_digits(value, 4);
    endtask

    function automatic logic [CP_W-1:0] plain_char(input logic [CP_W-1:0] quote);
        logic [CP_W-1:0] c;
        case ($urandom_range(0, 9))
            0, 1, 2: c = CP_W'($urandom_range(21'h20, 21'h7E));
            3:       c = CP_W'($urandom_range(21'h00, 21'h1F));
            4:       c = CP_W'($urandom_range(21'h80, 21'h7FF));
            5:       c = CP_W'($urandom_range(21'h800, 21'hFFFF));
            6:       c = CP_W'($urandom_range(21'hD800, 21'hDFFF));
            7, 8:    c = CP_W'($urandom_range(21'h10000, 21'h10FFFF));
            default: c = CP_W'($urandom_range(21'h110000, 21'h1FFFFF));
        endcase
        if (c == quote || c == CP_BACKSLASH)
            c = 21'h7E;
        return c;
    endfunction

    function automatic logic [CP_W-1:0] bad_hex_char();
        logic [CP_W-1:0] c;
        case ($urandom_range(0, 6))
            0:       c = 21'h67;                       // just past 'f'
            1:       c = 21'h47;                       // just past 'F'
            2:       c = 21'h2F;
            3:       c = 21'h3A;
            4:       c = 21'h40 | CP_W'($urandom_range(0, 1) << 5);
            5:       c = 21'h130 + CP_W'($urandom_range(0, 9));  // low byte looks like a digit
            default: c = CP_W'($urandom_range(21'h100, 21'h1FFFFF));
        endcase
        return c;
    endfunction

    function automatic logic [CP_W-1:0] bad_escape_char();
        logic [CP_W-1:0] c;
        case ($urandom_range(0, 5))
            0:       c = 21'h61;
            1:       c = 21'h78;
            2:       c = 21'h55;
            3:       c = 21'h30;
            4:       c = 21'h100 | CP_N;               // low byte is a valid escape
            default: c = CP_W'($urandom_range(21'h80, 21'h1FFFFF));
        endcase
        return c;
    endfunction

    function automatic logic [CP_W-1:0] simple_escape_char();
        logic [CP_W-1:0] c;
        case ($urandom_range(0, 7))
            0:       c = CP_QUOTE;
            1:       c = CP_BACKSLASH;
            2:       c = CP_SLASH;
            3:       c = CP_B;
            4:       c = CP_F;
            5:       c = CP_N;
            6:       c = CP_R;
            default: c = CP_T;
        endcase
        return c;
    endfunction

    task automatic push_token(input logic [CP_W-1:0] quote);
        logic [15:0] value;
        logic [9:0]  low_bits;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9:
                push_cp(plain_char(quote));
            10, 11, 12, 13:
            begin
                push_cp(CP_BACKSLASH);
                push_cp(simple_escape_char());
            end
            14, 15, 16:
            begin
                case ($urandom_range(0, 4))
                    0:       value = 16'($urandom_range(16'h0000, 16'h007F));
                    1:       value = 16'($urandom_range(16'h0080, 16'h07FF));
                    2:       value = 16'($urandom_range(16'h0800, 16'hD7FF));
                    3:       value = 16'($urandom_range(LOW_SUR_FIRST, LOW_SUR_LAST));
                    default: value = 16'($urandom_range(16'hE000, 16'hFFFF));
                endcase
                push_unicode_escape(value);
            end
            default:
            begin
                low_bits = 10'($urandom_range(0, 10'h3FF));
                push_unicode_escape(HIGH_SUR_FIRST + 16'($urandom_range(0, 16'h3FF)));
                push_unicode_escape(LOW_SUR_FIRST + {6'd0, low_bits});
            end
        endcase
    endtask

    // high surrogate followed by something that is not a proper low half
    task automatic push_broken_pair();
        logic [15:0] value;
        push_unicode_escape(HIGH_SUR_FIRST + 16'($urandom_range(0, 16'h3FF)));
        case ($urandom_range(0, 5))
            0:
                push_cp(CP_W'($urandom_range(21'h00, 21'h5B)));
            1:
            begin
                push_cp(CP_BACKSLASH);
                push_cp(CP_W'($urandom_range(21'h00, 21'h74)));
            end
            2:
            begin
                if ($urandom_range(0, 1) == 1)
                    value = 16'($urandom_range(16'h0000, 16'hDBFF));
                else
                    value = 16'($urandom_range(16'hE000, 16'hFFFF));
                push_unicode_escape(value);
            end
            3:
                push_eoi();
            4:
            begin
                push_cp(CP_BACKSLASH);
                push_eoi();
            end
            default:
            begin
                push_cp(CP_BACKSLASH);
                push_cp(CP_U);
                push_hex_digits(16'($urandom), int'($urandom_range(0, 3)));
                push_eoi();
            end
        endcase
    endtask

    task automatic push_random_string();
        logic [CP_W-1:0] quote;
        int              tokens;
        int              ending;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: quote = CP_QUOTE;
            6:                quote = 21'h27;
            7:                quote = CP_W'($urandom_range(21'h20, 21'h7E));
            default:          quote = CP_W'($urandom_range(21'h00, 21'h1FFFFF));
        endcase
        push_start(quote);
        tokens = int'($urandom_range(0, 8));
        for (int t = 0; t < tokens; t++)
            push_token(quote);
        ending = int'($urandom_range(0, 15));
        if (ending <= 8)
        begin
            push_cp(quote);
        end
        else
        begin
            case (ending)
                9:
                    push_eoi();
                10:
                begin
                    push_cp(CP_BACKSLASH);
                    push_cp(bad_escape_char());
                end
                11:
                begin
                    push_cp(CP_BACKSLASH);
                    push_eoi();
                end
                12:
                begin
                    push_cp(CP_BACKSLASH);
                    push_cp(CP_U);
                    push_hex_digits(16'($urandom), int'($urandom_range(0, 3)));
                    push_cp(bad_hex_char());
                end
                13:
                begin
                    push_cp(CP_BACKSLASH);
                    push_cp(CP_U);
                    push_hex_digits(16'($urandom), int'($urandom_range(0, 3)));
                    push_eoi();
                end
                14:
                    push_broken_pair();
                default:
                    ;   // left open; the next start abandons it
            endcase
        end
    endtask

    // ---------------- driver ----------------

    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || in_taken))
        begin
            in_taken = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (code_point_q.size() > 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {3'b000, code_point_q[0].cp};
                s_axis_tuser  <= {code_point_q[0].start, code_point_q[0].eoi};
                if (burst_left > 1)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = int'($urandom_range(1, 24));
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
                end
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver back-pressure from a rotating pattern that is swapped now and then
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       stall_pattern = 16'hFFFF;
                    1:       stall_pattern = 16'($urandom) | 16'h0001;
                    2:       stall_pattern = 16'h0001;
                    default: stall_pattern = 16'($urandom) | 16'h0101;
                endcase
                stall_left = int'($urandom_range(20, 80));
            end
            stall_left--;
            m_axis_tready <= stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
        end
    end

    // ---------------- monitor ----------------

    task automatic check_result();
        utf8_result_t want;
        logic [7:0]   got_data;
        logic [2:0]   got_err;
        logic [1:0]   got_kind;
        got_data = m_axis_tdata[7:0];
        got_err  = m_axis_tdata[10:8];
        got_kind = m_axis_tuser;
        results_checked++;
        case (got_kind)
            KIND_DATA:  bytes_seen++;
            KIND_CLOSE: closes_seen++;
            default:    errors_seen++;
        endcase
        if (expected_out_q.size() == 0)
        begin
            if (mismatch_count < MAX_REPORTS)
                $display("unexpected result: byte %02h kind %0d err %0d last %0b",
                         got_data, got_kind, got_err, m_axis_tlast);
            mismatch_count++;
        end
        else
        begin
            want = expected_out_q.pop_front();
            if (got_data !== want.data || got_kind !== want.kind || got_err !== want.err
                || m_axis_tlast !== want.last)
            begin
                if (mismatch_count < MAX_REPORTS)
                begin
                    $display("mismatch at result %0d: expected byte %02h kind %0d err %0d last %0b",
                             results_checked, want.data, want.kind, want.err, want.last);
                    $display("    got byte %02h kind %0d err %0d last %0b",
                             got_data, got_kind, got_err, m_axis_tlast);
                end
                mismatch_count++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                unescape_item(code_point_q.pop_front());
                in_taken = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready)
                check_result();
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= TIMEOUT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_out_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial
    begin
        // directed: encoding lengths, dropped code points, escapes, pairs, lone halves
        push_start(CP_QUOTE);
        push_cp(21'h000000);
        push_cp(21'h00007F);
        push_cp(21'h0007FF);
        push_cp(21'h00FFFF);
        push_cp(CP_MAX);
        push_cp(21'h1FFFFF);            // beyond unicode, dropped
        push_cp(21'h00DFFF);            // raw surrogate in the body
        push_cp(CP_BACKSLASH);
        push_cp(CP_QUOTE);              // escaped quote must not close
        push_unicode_escape(16'hD83D);
        push_unicode_escape(16'hDE00);
        push_cp(CP_QUOTE);
        push_eoi();                     // idle, ignored
        push_start(21'h1FFFFF);
        push_unicode_escape(16'hDC00);  // lone low half
        push_cp(21'h1FFFFF);
        push_start(21'h000027);
        push_eoi();

        while (items_queued < TARGET_ITEMS)
        begin
            // noise between strings is counted apart
            if ($urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    code_point_q.push_back('{cp: CP_W'($urandom), eoi: 1'($urandom),
                                              start: 1'b0});
                    noise_queued++;
                end
            end
            push_random_string();
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (code_point_q.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_out_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_out_q.size() > 0)
        begin
            $display("%0d expected results never arrived", expected_out_q.size());
            mismatch_count += expected_out_q.size();
        end

        $display("%0d input transactions over %0d strings plus %0d filler; %0d results checked",
                 items_queued, strings_queued, noise_queued, results_checked);
        $display("%0d utf-8 bytes, %0d closed strings, %0d errors, %0d mismatches",
                 bytes_seen, closes_seen, errors_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[sim.f]
sv/jsu_pkg.sv
sv/json_string_unescape_utf8.sv
dv/json_string_unescape_utf8_test.sv
